// ----- rtl/cbp_pkg.sv -----
// shared constants for the codeword bit packer
package cbp_pkg;

   // bits in one emitted byte
   localparam int BYTE_W = 8;
   // width of the held-back partial byte
   localparam int PEND_W = BYTE_W - 1;
   // default longest codeword
   localparam int MAX_CODE_BITS_DEF = 32;
   // entries in the queue between front and back
   localparam int QUEUE_DEPTH_DEF = 4;
   // widths of the request ports
   localparam int CODE_PORT_W = 32;
   localparam int LEN_PORT_W = 6;

endpackage

// ----- rtl/cbp_front.sv -----
// front end: merges each codeword with the pending bits and builds a queue entry
module cbp_front #(
   parameter int MAX_CODE_BITS = 32,
   parameter int WORD_W = 40,
   parameter int NB_W = 3
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [cbp_pkg::CODE_PORT_W-1:0] req_code_bits,
   input  logic [cbp_pkg::LEN_PORT_W-1:0]  req_code_len,
   input  logic                           req_last_word,
   input  logic                           queue_full,
   output logic                           push,
   output logic [WORD_W-1:0]              push_word,
   output logic [NB_W-1:0]                push_nbytes,
   output logic                           push_last
);
   import cbp_pkg::*;

   localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);
   localparam int TOT_W = $clog2(MAX_CODE_BITS + BYTE_W);
   localparam int SH_W  = $clog2(WORD_W + 1);

   logic [PEND_W-1:0] pbits_ff, pbits_in;
   logic [2:0]        pcount_ff, pcount_in;
   logic              accept;
   logic [LEN_W-1:0]  len_sat;
   logic [WORD_W-1:0] code_w;
   logic [WORD_W-1:0] acc;
   logic [TOT_W-1:0]  total;
   logic [SH_W-1:0]   shift;
   logic [2:0]        rem;
   logic [NB_W-1:0]   full_bytes;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // saturate the length and mask the codeword
   always_comb begin
      if (req_code_len > LEN_PORT_W'(MAX_CODE_BITS)) begin
         len_sat = LEN_W'(MAX_CODE_BITS);
      end else begin
         len_sat = req_code_len[LEN_W-1:0];
      end
      code_w = WORD_W'(req_code_bits[MAX_CODE_BITS-1:0]) & ~({WORD_W{1'b1}} << len_sat);
   end

   // append the codeword to the pending bits, then left-align with ones below
   always_comb begin
      acc         = (WORD_W'(pbits_ff) << len_sat) | code_w;
      total       = TOT_W'(pcount_ff) + TOT_W'(len_sat);
      shift       = SH_W'(WORD_W) - SH_W'(total);
      push_word   = (acc << shift) | ~({WORD_W{1'b1}} << shift);
      rem         = total[2:0];
      full_bytes  = NB_W'(total >> 3);
      push_nbytes = full_bytes + NB_W'(req_last_word && (rem != 3'd0));
      push_last   = req_last_word;
      push        = accept && (push_nbytes != '0);
   end

   // next pending state
   always_comb begin
      pbits_in  = pbits_ff;
      pcount_in = pcount_ff;
      if (accept) begin
         if (req_last_word) begin
            pbits_in  = '0;
            pcount_in = '0;
         end else begin
            pbits_in  = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << rem);
            pcount_in = rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pbits_ff  <= '0;
         pcount_ff <= '0;
      end else begin
         pbits_ff  <= pbits_in;
         pcount_ff <= pcount_in;
      end
   end

endmodule

// ----- rtl/cbp_queue.sv -----
// small fifo of packed words between the front and back ends
module cbp_queue #(
   parameter int WIDTH = 44,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] head_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_data = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage write
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count out of range");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue fill count missed a write");
`endif

endmodule

// ----- rtl/cbp_back.sv -----
// back end: walks the head entry one byte a cycle into the response register while the receiver keeps up
module cbp_back #(
   parameter int WORD_W = 40,
   parameter int NB_W = 3
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      empty,
   input  logic [WORD_W-1:0]         head_word,
   input  logic [NB_W-1:0]           head_nbytes,
   input  logic                      head_last,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [cbp_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                      rsp_last_byte
);
   import cbp_pkg::*;

   logic [NB_W-1:0]   idx_ff, idx_in;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              last_ff, last_in;
   logic              load;
   logic              final_of_entry;
   logic [WORD_W-1:0] shifted;

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_last_byte = last_ff;

   // byte selection and response register load
   always_comb begin
      load           = !empty && (!valid_ff || rsp_ready);
      final_of_entry = (idx_ff == head_nbytes - 1'b1);
      pop            = load && final_of_entry;
      shifted        = head_word << {idx_ff, 3'b000};
      idx_in         = idx_ff;
      valid_in       = valid_ff;
      byte_in        = byte_ff;
      last_in        = last_ff;
      if (load) begin
         idx_in   = final_of_entry ? '0 : idx_ff + 1'b1;
         valid_in = 1'b1;
         byte_in  = shifted[WORD_W-1 -: BYTE_W];
         last_in  = head_last && final_of_entry;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

endmodule

// ----- rtl/codeword_bit_packer.sv -----
// codeword bit packer top level: front end, entry queue and byte emitter
// a request's first byte is registered in the queue, then in the response register
// throughput: one request a cycle while the queue has room; output is one byte a cycle
// while an entry waits and the receiver is ready, so the byte emitter sets the rate;
// the queue holds up to QUEUE_DEPTH entries in flight
// reset (synchronous, active high) clears pending bits, queue and output valid
module codeword_bit_packer #(
   parameter int MAX_CODE_BITS = cbp_pkg::MAX_CODE_BITS_DEF,
   parameter int QUEUE_DEPTH = cbp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [cbp_pkg::CODE_PORT_W-1:0] req_code_bits,
   input  logic [cbp_pkg::LEN_PORT_W-1:0]  req_code_len,
   input  logic                           req_last_word,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [cbp_pkg::BYTE_W-1:0]     rsp_out_byte,
   output logic                           rsp_last_byte
);
   import cbp_pkg::*;

   localparam int MAX_BYTES = (MAX_CODE_BITS + PEND_W + BYTE_W - 1) / BYTE_W;
   localparam int WORD_W    = MAX_BYTES * BYTE_W;
   localparam int NB_W      = $clog2(MAX_BYTES + 1);
   localparam int ENTRY_W   = WORD_W + NB_W + 1;

   logic              queue_full;
   logic              queue_empty;
   logic              push;
   logic              pop;
   logic [WORD_W-1:0] push_word;
   logic [NB_W-1:0]   push_nbytes;
   logic              push_last;
   logic [ENTRY_W-1:0] head_entry;

   // merge codewords with pending bits
   cbp_front #(
      .MAX_CODE_BITS (MAX_CODE_BITS),
      .WORD_W        (WORD_W),
      .NB_W          (NB_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_code_bits (req_code_bits),
      .req_code_len  (req_code_len),
      .req_last_word (req_last_word),
      .queue_full    (queue_full),
      .push          (push),
      .push_word     (push_word),
      .push_nbytes   (push_nbytes),
      .push_last     (push_last)
   );

   // decoupling queue
   cbp_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_word, push_nbytes, push_last}),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .head_data (head_entry)
   );

   // byte emitter
   cbp_back #(
      .WORD_W (WORD_W),
      .NB_W   (NB_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .empty         (queue_empty),
      .head_word     (head_entry[ENTRY_W-1 -: WORD_W]),
      .head_nbytes   (head_entry[NB_W:1]),
      .head_last     (head_entry[0]),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

// ----- verif/tb_codeword_bit_packer.sv -----
// testbench for the codeword bit packer: random and directed requests against a byte predictor
module tb_codeword_bit_packer;
   timeunit 1ns;
   timeprecision 1ps;

   import cbp_pkg::*;

   localparam int MAX_BITS = MAX_CODE_BITS_DEF;
   localparam int RANDOM_REQUESTS = 64;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 20;
   localparam int MAX_GAP = 14;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } packed_byte_type;

   // predicts the byte stream and compares what the block emits
   class packer_scoreboard_type;
      logic [PEND_W-1:0] held_bits;
      int unsigned       held_count;
      packed_byte_type   expected_bytes[$];
      int                errors;

      function new();
         held_bits = '0;
         held_count = 0;
         errors = 0;
      endfunction

      function void report_error(string what, packed_byte_type want, packed_byte_type got);
         errors++;
         if (errors <= 10) begin
            $display("%t %s: expected %02h last %0b, got %02h last %0b", $realtime, what,
                     want.data, want.last, got.data, got.last);
         end
      endfunction

      // append one codeword and queue every byte it completes
      function void note_request(logic [CODE_PORT_W-1:0] code, logic [LEN_PORT_W-1:0] len_in,
                                 logic last);
         int unsigned     len;
         int unsigned     total;
         int unsigned     padw;
         int              produced;
         logic [63:0]     acc;
         logic [63:0]     mask;
         packed_byte_type b;
         len = len_in;
         if (len > MAX_BITS) len = MAX_BITS;
         mask = (64'd1 << len) - 64'd1;
         acc = ({57'd0, held_bits} << len) | ({32'd0, code} & mask);
         total = held_count + len;
         produced = 0;
         // full bytes, earliest bit in the top position
         while (total >= 8) begin
            b.data = 8'(acc >> (total - 8));
            b.last = 1'b0;
            expected_bytes.push_back(b);
            produced++;
            total -= 8;
         end
         acc &= (64'd1 << total) - 64'd1;
         if (last) begin
            // pad the partial byte with ones and mark the final byte
            if (total > 0) begin
               padw = 8 - total;
               b.data = 8'((acc << padw) | ((64'd1 << padw) - 64'd1));
               b.last = 1'b0;
               expected_bytes.push_back(b);
               produced++;
            end
            if (produced > 0) begin
               b = expected_bytes.pop_back();
               b.last = 1'b1;
               expected_bytes.push_back(b);
            end
            held_bits = '0;
            held_count = 0;
         end else begin
            held_bits = acc[PEND_W-1:0];
            held_count = total;
         end
      endfunction

      // compare one emitted byte with the oldest prediction
      function void check_byte(logic [BYTE_W-1:0] data, logic last);
         packed_byte_type got;
         packed_byte_type want;
         got.data = data;
         got.last = last;
         if (expected_bytes.size() == 0) begin
            want = '0;
            report_error("unexpected byte", want, got);
         end else begin
            want = expected_bytes.pop_front();
            if (want.data !== got.data || want.last !== got.last) begin
               report_error("byte mismatch", want, got);
            end
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [CODE_PORT_W-1:0] req_code_bits;
   logic [LEN_PORT_W-1:0]  req_code_len;
   logic                   req_last_word;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [BYTE_W-1:0]      rsp_out_byte;
   logic                   rsp_last_byte;

   packer_scoreboard_type sb;
   bit sender_steady;
   bit receiver_steady;
   bit hold_off_request;

   codeword_bit_packer u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_code_bits (req_code_bits),
      .req_code_len  (req_code_len),
      .req_last_word (req_last_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // offer one request after a random gap (none when the sender is steady) and hold it until accepted
   task automatic send_request(logic [CODE_PORT_W-1:0] code, logic [LEN_PORT_W-1:0] len,
                               logic last);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, MAX_GAP);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_code_bits <= code;
      req_code_len <= len;
      req_last_word <= last;
      do @(posedge clock); while (!req_ready);
      sb.note_request(code, len, last);
   endtask

   // stop offering and wait for every predicted byte
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_bytes.size() != 0) @(posedge clock);
   endtask

   // receiver: random back-pressure, one long hold-off on request
   initial begin : receiver
      int gap;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (hold_off_request) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off_request = 1'b0;
         end
         gap = receiver_steady ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // check every accepted byte
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_byte(rsp_out_byte, rsp_last_byte);
      end
   end

   // give up when nothing moves for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("tb_codeword_bit_packer: FAIL");
      $finish;
   end

   // stimulus
   initial begin : main
      int sent;
      int words;
      int pick;
      logic [LEN_PORT_W-1:0] len;
      logic last;
      sb = new();
      sender_steady = 1'b0;
      receiver_steady = 1'b0;
      hold_off_request = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_code_bits = '0;
      req_code_len = '0;
      req_last_word = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes and the corner cases
      send_request(32'hFFFF_FFFF, 6'd32, 1'b0);
      send_request(32'h0000_0000, 6'd32, 1'b0);
      send_request(32'h0000_0001, 6'd1, 1'b1);
      send_request(32'h0000_0000, 6'd1, 1'b1);
      // last word that ends exactly on a byte boundary
      send_request(32'h0000_00A5, 6'd8, 1'b1);
      // last word with nothing pending and no bits
      send_request(32'h0000_0000, 6'd0, 1'b1);
      // three bits, not last, then zero length, not last: nothing is emitted
      send_request(32'h0000_0005, 6'd3, 1'b0);
      send_request(32'hFFFF_FFFF, 6'd0, 1'b0);
      // zero-length last word flushes pending bits
      send_request(32'h0000_0000, 6'd0, 1'b1);
      // seven pending bits plus a full codeword gives five bytes
      send_request(32'h0000_0055, 6'd7, 1'b0);
      send_request(32'hDEAD_BEEF, 6'd32, 1'b1);
      // lengths above the maximum saturate
      send_request(32'hFFFF_FFFF, 6'd33, 1'b0);
      send_request(32'h1234_5678, 6'd63, 1'b1);
      // bits above the length are ignored
      send_request(32'hFFFF_FFF0, 6'd4, 1'b0);
      send_request(32'hFFFF_FFF0, 6'd4, 1'b1);
      send_request(32'hAAAA_AAAA, 6'd16, 1'b0);
      send_request(32'h0000_5555, 6'd16, 1'b0);
      send_request(32'h0000_0000, 6'd8, 1'b1);
      send_request(32'h8000_0000, 6'd31, 1'b0);
      send_request(32'h0000_0001, 6'd1, 1'b1);
      send_request(32'h0000_0003, 6'd2, 1'b0);
      send_request(32'h0000_0009, 6'd4, 1'b0);
      send_request(32'h7FFF_FFFF, 6'd31, 1'b1);
      drain_results();

      // back-to-back full codewords while the receiver holds off
      hold_off_request = 1'b1;
      sender_steady = 1'b1;
      repeat (12) send_request($urandom, 6'd32, 1'b0);
      send_request($urandom, 6'($urandom_range(1, 32)), 1'b1);
      sender_steady = 1'b0;
      drain_results();

      // random strings, mostly well formed, with some noise lengths
      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         words = $urandom_range(1, 8);
         for (int w = 0; w < words; w++) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) len = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
            else if (pick < 70) len = 6'($urandom_range(1, 12));
            else len = 6'($urandom_range(13, 32));
            // now and then a string runs on without its last word
            last = (w == words - 1) && ($urandom_range(0, 9) != 0);
            send_request($urandom, len, last);
            sent++;
            // a stretch with no idling on either side
            if (sent == 40) begin
               sender_steady = 1'b1;
               receiver_steady = 1'b1;
            end
            if (sent == 60) begin
               sender_steady = 1'b0;
               receiver_steady = 1'b0;
            end
         end
      end
      send_request($urandom, 6'($urandom_range(1, 32)), 1'b1);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (sb.errors == 0 && sb.expected_bytes.size() == 0) begin
         $display("tb_codeword_bit_packer: PASS");
      end else begin
         $display("tb_codeword_bit_packer: FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/cbp_pkg.sv
rtl/cbp_front.sv
rtl/cbp_queue.sv
rtl/cbp_back.sv
rtl/codeword_bit_packer.sv
verif/tb_codeword_bit_packer.sv
